### design/wcta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcta_pkg
// shared constants and codes for the wall column texel address generator
// ----------------------------------------------------------------------------
package wcta_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int HIT_FRAC_BITS = 16;
    localparam int ACC_W         = 40;
    localparam int TEX_DIM_W     = 13;
    localparam int HEIGHT_W      = 24;
    localparam int DIV_W         = TEX_DIM_W + FRAC_BITS + 8;

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;

    localparam logic [1:0] OP_TEX   = 2'd0;
    localparam logic [1:0] OP_FILL  = 2'd1;
    localparam logic [1:0] OP_PIXEL = 2'd2;

    localparam logic [2:0] CFG_SCREEN_LINE = 3'd0;
    localparam logic [2:0] CFG_BPP         = 3'd1;
    localparam logic [2:0] CFG_TEX_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_TEX_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_TEX_LINE    = 3'd4;

endpackage

### design/wall_column_texel_address_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_column_texel_address_gen
// screen and texel address generator for one raycaster wall column
// ----------------------------------------------------------------------------
// one beat at a time goes through a single shared 32x16 multiplier under a
// small sequencer; s_axis_tready is low while a beat is in work. a next-pixel
// beat forms row times texture line length, then loads the output register,
// which waits while the previous result is still held; a start-fill beat forms
// the screen start address, and a start-texture beat also waits on the
// 37-step shift-subtract divider for the row step.
// results sit in an output register, so the next beat is taken while one waits
module wall_column_texel_address_gen (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // column_x, start_row, end_row, hit_x, hit_y, wall_is_vertical,
    // wall_height, skip_rows, tex_base, fill_color, zero pad
    input  logic [199:0] s_axis_tdata,
    // op
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pixel_addr, texel_addr, color_out
    output logic [95:0]  m_axis_tdata,
    // from_texture
    output logic         m_axis_tuser,
    // last_pixel
    output logic         m_axis_tlast
);

    localparam int TW = wcta_pkg::TEX_DIM_W;

    typedef enum logic [3:0] {
        S_IDLE, S_R0, S_R1, S_R2, S_T0, S_T1, S_T2, S_WDIV, S_T3, S_T4, S_P0, S_P1
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0]   r_sll;
    logic [3:0]    r_bpp;
    logic [TW-1:0] r_tw;
    logic [TW-1:0] r_th;
    logic [15:0]   r_tll;

    // run state
    logic                       r_run_active;
    logic                       r_run_textured;
    logic [11:0]                r_cur;
    logic [11:0]                r_stop;
    logic [31:0]                r_wa;
    logic [31:0]                r_tca;
    logic [31:0]                r_step;
    logic [wcta_pkg::ACC_W-1:0] r_acc;
    logic [31:0]                r_held;

    // captured start fields
    logic [11:0] r_colx;
    logic [11:0] r_start;
    logic [15:0] r_frac;
    logic [15:0] r_skip;
    logic [31:0] r_base;
    logic        r_hzero;

    // shared multiplier
    logic [wcta_pkg::MUL_A_W-1:0]                   mul_a;
    logic [wcta_pkg::MUL_B_W-1:0]                   mul_b;
    logic [wcta_pkg::MUL_A_W+wcta_pkg::MUL_B_W-1:0] r_prod;

    // output register
    logic        r_out_valid;
    logic [31:0] r_pix;
    logic [31:0] r_tex;
    logic [31:0] r_col;
    logic        r_from;
    logic        r_last;

    logic                       s_accept;
    logic [1:0]                 op;
    logic                       div_busy;
    logic [wcta_pkg::DIV_W-1:0] div_q;
    logic [wcta_pkg::DIV_W-1:0] dividend;
    logic [63:0]                q_ext;
    logic [31:0]                step_sat;
    logic [TW-1:0]              col;
    logic [TW-1:0]              row_lim;
    logic [wcta_pkg::ACC_W-1:0] row_full;
    logic [TW-1:0]              row_clamp;
    logic [wcta_pkg::ACC_W:0]   acc_sum;
    logic [wcta_pkg::ACC_W-1:0] acc_next;
    logic [wcta_pkg::ACC_W-1:0] acc_start;
    logic                       is_last;
    logic                       out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign op            = s_axis_tuser;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign dividend = wcta_pkg::DIV_W'(r_th) << (wcta_pkg::FRAC_BITS + 8);

    wcta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (s_accept && op == wcta_pkg::OP_TEX),
        .i_dividend (dividend),
        .i_divisor  (s_axis_tdata[116:93]),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    assign q_ext    = 64'(div_q);
    assign step_sat = (r_hzero || |q_ext[63:32]) ? 32'hFFFF_FFFF : q_ext[31:0];

    assign col = r_prod[wcta_pkg::HIT_FRAC_BITS+TW-1:wcta_pkg::HIT_FRAC_BITS];

    assign row_lim   = (r_th != '0) ? r_th - 1'b1 : '0;
    assign row_full  = r_acc >> wcta_pkg::FRAC_BITS;
    assign row_clamp = (row_full > wcta_pkg::ACC_W'(row_lim)) ? row_lim : row_full[TW-1:0];

    assign acc_sum  = {1'b0, r_acc} + (wcta_pkg::ACC_W + 1)'(r_step);
    assign acc_next = acc_sum[wcta_pkg::ACC_W] ? '1 : acc_sum[wcta_pkg::ACC_W-1:0];
    assign acc_start = (|r_prod[wcta_pkg::MUL_A_W+wcta_pkg::MUL_B_W-1:wcta_pkg::ACC_W])
                       ? '1 : r_prod[wcta_pkg::ACC_W-1:0];

    assign is_last = ({1'b0, r_cur} + 13'd1) >= {1'b0, r_stop};

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_R0: begin
                mul_a = wcta_pkg::MUL_A_W'(r_start);
                mul_b = r_sll;
            end
            S_R1: begin
                mul_a = wcta_pkg::MUL_A_W'(r_colx);
                mul_b = wcta_pkg::MUL_B_W'(r_bpp);
            end
            S_T0: begin
                mul_a = wcta_pkg::MUL_A_W'(r_frac);
                mul_b = wcta_pkg::MUL_B_W'(r_tw);
            end
            S_T1: begin
                mul_a = wcta_pkg::MUL_A_W'(col);
                mul_b = wcta_pkg::MUL_B_W'(r_bpp);
            end
            S_T3: begin
                mul_a = r_step;
                mul_b = r_skip;
            end
            // held through the output wait so the product stays valid
            S_P0, S_P1: begin
                mul_a = wcta_pkg::MUL_A_W'(row_clamp);
                mul_b = r_tll;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sll <= 16'd7680;
            r_bpp <= 4'd4;
            r_tw  <= TW'(64);
            r_th  <= TW'(64);
            r_tll <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                wcta_pkg::CFG_SCREEN_LINE: r_sll <= i_cfg_wdata;
                wcta_pkg::CFG_BPP:         r_bpp <= i_cfg_wdata[3:0];
                wcta_pkg::CFG_TEX_WIDTH:   r_tw  <= i_cfg_wdata[TW-1:0];
                wcta_pkg::CFG_TEX_HEIGHT:  r_th  <= i_cfg_wdata[TW-1:0];
                wcta_pkg::CFG_TEX_LINE:    r_tll <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_run_active   <= 1'b0;
            r_run_textured <= 1'b0;
            r_cur          <= '0;
            r_stop         <= '0;
            r_wa           <= '0;
            r_tca          <= '0;
            r_step         <= '0;
            r_acc          <= '0;
            r_held         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_P1) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_colx  <= s_axis_tdata[11:0];
                        r_start <= s_axis_tdata[23:12];
                        r_frac  <= s_axis_tdata[92] ? s_axis_tdata[79:64]
                                                    : s_axis_tdata[51:36];
                        r_hzero <= (s_axis_tdata[116:93] == '0);
                        r_skip  <= s_axis_tdata[132:117];
                        r_base  <= s_axis_tdata[164:133];
                        if (op == wcta_pkg::OP_TEX || op == wcta_pkg::OP_FILL) begin
                            r_cur          <= s_axis_tdata[23:12];
                            r_stop         <= s_axis_tdata[35:24];
                            r_run_active   <= s_axis_tdata[23:12] < s_axis_tdata[35:24];
                            r_run_textured <= (op == wcta_pkg::OP_TEX);
                            r_held         <= (op == wcta_pkg::OP_TEX)
                                              ? 32'd0 : s_axis_tdata[196:165];
                            r_state        <= S_R0;
                        end else if (op == wcta_pkg::OP_PIXEL && r_run_active) begin
                            r_state <= S_P0;
                        end
                    end
                end
                S_R0: r_state <= S_R1;
                S_R1: begin
                    r_wa    <= r_prod[31:0];
                    r_state <= S_R2;
                end
                S_R2: begin
                    r_wa    <= r_wa + r_prod[31:0];
                    r_state <= r_run_textured ? S_T0 : S_IDLE;
                end
                S_T0: r_state <= S_T1;
                S_T1: r_state <= S_T2;
                S_T2: begin
                    r_tca   <= r_base + r_prod[31:0];
                    r_state <= S_WDIV;
                end
                S_WDIV: begin
                    if (!div_busy) begin
                        r_step  <= step_sat;
                        r_state <= S_T3;
                    end
                end
                S_T3: r_state <= S_T4;
                S_T4: begin
                    r_acc   <= acc_start;
                    r_state <= S_IDLE;
                end
                S_P0: r_state <= S_P1;
                S_P1: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_pix       <= r_wa;
                        r_tex       <= r_run_textured ? r_tca + r_prod[31:0] : 32'd0;
                        r_col       <= r_run_textured ? 32'd0 : r_held;
                        r_from      <= r_run_textured;
                        r_last      <= is_last;
                        r_wa        <= r_wa + 32'(r_sll);
                        r_cur       <= r_cur + 1'b1;
                        if (r_run_textured) begin
                            r_acc <= acc_next;
                        end
                        if (is_last) begin
                            r_run_active <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_col, r_tex, r_pix};
    assign m_axis_tuser  = r_from;
    assign m_axis_tlast  = r_last;

`ifndef SYNTHESIS
    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    a_last_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P1 && out_free && is_last) |=> !r_run_active)
        else $error("run still open after last pixel");

    a_texel_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[95:64] == 32'd0))
        else $error("texel beat carries a fill value");

    a_fill_no_texel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[63:32] == 32'd0))
        else $error("fill beat carries a texel address");
`endif

endmodule

### design/wcta_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcta_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wcta_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wcta_pkg::DIV_W-1:0]    i_dividend,
    input  logic [wcta_pkg::HEIGHT_W-1:0] i_divisor,
    output logic                          o_busy,
    output logic [wcta_pkg::DIV_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(wcta_pkg::DIV_W + 1);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [wcta_pkg::DIV_W-1:0]    r_quo;
    logic [wcta_pkg::HEIGHT_W-1:0] r_rem;
    logic [wcta_pkg::HEIGHT_W-1:0] r_div;
    logic [wcta_pkg::HEIGHT_W:0]   trial;
    logic                          fits;

    assign trial = {r_rem, r_quo[wcta_pkg::DIV_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(wcta_pkg::DIV_W);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
            if (fits) begin
                r_rem <= wcta_pkg::HEIGHT_W'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[wcta_pkg::HEIGHT_W-1:0];
            end
            r_quo <= {r_quo[wcta_pkg::DIV_W-2:0], fits};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

### dv/wall_column_texel_address_gen_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_column_texel_address_gen_tb
// self-checking bench for the raycaster wall column address generator
// ----------------------------------------------------------------------------
// column beats are queued by the stimulus process and sent by a clocked driver
// with random gaps. every accepted beat goes through a column predictor that
// keeps its own run state and register copies and queues the pixel beats it
// should cause. a clocked monitor stalls the output at random and checks each
// pixel beat against the oldest queued one. the run goes through several
// register settings (reset, both extremes, zero texture height, random in-range and raw values),
// each opened with directed corner cases or straight into random runs.
// ----------------------------------------------------------------------------
module wall_column_texel_address_gen_tb;

    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [63:0] ACC_SAT   = (64'd1 << wcta_pkg::ACC_W) - 1;
    localparam logic [63:0] STEP_SAT  = 64'hFFFF_FFFF;
    localparam int          SETTLE    = 60;

    typedef struct packed {
        bit [1:0]  op;
        bit [11:0] column_x;
        bit [11:0] start_row;
        bit [11:0] end_row;
        bit [27:0] hit_x;
        bit [27:0] hit_y;
        bit        vertical;
        bit [23:0] wall_height;
        bit [15:0] skip_rows;
        bit [31:0] tex_base;
        bit [31:0] fill_color;
    } t_column_beat;

    typedef struct packed {
        logic [31:0] pixel_addr;
        logic [31:0] texel_addr;
        logic [31:0] color_out;
        logic        from_texture;
        logic        last_pixel;
    } t_pixel;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [15:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [199:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;

    wall_column_texel_address_gen dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    // register copies
    bit [15:0] cfg_screen_line = 16'd7680;
    bit [3:0]  cfg_bpp         = 4'd4;
    bit [12:0] cfg_tex_w       = 13'd64;
    bit [12:0] cfg_tex_h       = 13'd64;
    bit [15:0] cfg_tex_line    = 16'd256;

    // predicted run state
    bit        run_open;
    bit        run_tex;
    bit [11:0] row_now;
    bit [11:0] row_stop;
    bit [31:0] scr_addr;
    bit [31:0] tex_col_addr;
    bit [31:0] row_step;
    bit [39:0] accum;
    bit [31:0] fill_hold;

    t_column_beat beat_q[$];
    t_pixel       pending_pixels[$];
    t_column_beat cur_beat;
    bit           beat_busy;
    int unsigned  s_gap, m_stall;
    bit           s_steady, m_steady;
    t_pixel       got, want;

    int unsigned items_queued, beats_sent, pixels_checked, tex_pixels, run_ends;
    int unsigned mismatches, settings;

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    endfunction

    function automatic t_column_beat random_beat(input logic [1:0] op);
        t_column_beat b;
        b.op          = op;
        b.column_x    = 12'($urandom);
        b.start_row   = 12'($urandom);
        b.end_row     = 12'($urandom);
        b.hit_x       = 28'($urandom);
        b.hit_y       = 28'($urandom);
        b.vertical    = 1'($urandom);
        b.wall_height = 24'($urandom);
        b.skip_rows   = 16'($urandom);
        b.tex_base    = $urandom;
        b.fill_color  = $urandom;
        return b;
    endfunction

    task automatic open_run(input t_column_beat b);
        scr_addr = 32'(64'(b.start_row) * cfg_screen_line + 64'(b.column_x) * cfg_bpp);
        row_now  = b.start_row;
        row_stop = b.end_row;
        run_open = b.start_row < b.end_row;
    endtask

    task automatic predict_pixel(input t_column_beat b);
        bit [63:0] frac, col, quot, acc, trow, tlim;
        t_pixel    px;
        case (b.op)
            wcta_pkg::OP_TEX: begin
                frac = b.vertical ? 64'(b.hit_y[wcta_pkg::HIT_FRAC_BITS-1:0])
                                  : 64'(b.hit_x[wcta_pkg::HIT_FRAC_BITS-1:0]);
                col  = (frac * cfg_tex_w) >> wcta_pkg::HIT_FRAC_BITS;
                if (b.wall_height == 0) begin
                    quot = STEP_SAT;
                end else begin
                    quot = (64'(cfg_tex_h) << (wcta_pkg::FRAC_BITS + 8)) / b.wall_height;
                    if (quot > STEP_SAT) quot = STEP_SAT;
                end
                row_step     = quot[31:0];
                acc          = 64'(b.skip_rows) * quot;
                accum        = (acc > ACC_SAT) ? ACC_SAT[39:0] : acc[39:0];
                tex_col_addr = b.tex_base + 32'(col * cfg_bpp);
                fill_hold    = '0;
                run_tex      = 1'b1;
                open_run(b);
            end
            wcta_pkg::OP_FILL: begin
                fill_hold = b.fill_color;
                run_tex   = 1'b0;
                open_run(b);
            end
            wcta_pkg::OP_PIXEL: begin
                if (run_open) begin
                    px.pixel_addr = scr_addr;
                    if (run_tex) begin
                        trow = 64'(accum) >> wcta_pkg::FRAC_BITS;
                        tlim = (cfg_tex_h != 0) ? 64'(cfg_tex_h) - 1 : 64'd0;
                        if (trow > tlim) trow = tlim;
                        px.texel_addr   = tex_col_addr + 32'(trow * cfg_tex_line);
                        px.color_out    = '0;
                        px.from_texture = 1'b1;
                    end else begin
                        px.texel_addr   = '0;
                        px.color_out    = fill_hold;
                        px.from_texture = 1'b0;
                    end
                    px.last_pixel = (32'(row_now) + 1 >= 32'(row_stop));
                    pending_pixels.push_back(px);
                    scr_addr = scr_addr + cfg_screen_line;
                    row_now  = row_now + 1'b1;
                    if (run_tex) begin
                        acc   = 64'(accum) + 64'(row_step);
                        accum = (acc > ACC_SAT) ? ACC_SAT[39:0] : acc[39:0];
                    end
                    if (px.last_pixel) run_open = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pixel(cur_beat);
                beats_sent++;
                beat_busy = 1'b0;
                if (!s_steady && $urandom_range(0, 99) >= 55) s_gap = pick_gap();
            end
            if (!beat_busy) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (beat_q.size() > 0) begin
                    cur_beat  = beat_q.pop_front();
                    beat_busy = 1'b1;
                end
            end
            s_axis_tvalid <= beat_busy;
            s_axis_tdata  <= {3'b000, cur_beat.fill_color, cur_beat.tex_base,
                              cur_beat.skip_rows, cur_beat.wall_height, cur_beat.vertical,
                              cur_beat.hit_y, cur_beat.hit_x, cur_beat.end_row,
                              cur_beat.start_row, cur_beat.column_x};
            s_axis_tuser  <= cur_beat.op;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                       m_axis_tuser, m_axis_tlast};
                if (pending_pixels.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pixel beat: addr=%h texel=%h colour=%h %s%b %s%b",
                                 got.pixel_addr, got.texel_addr, got.color_out,
                                 "tex=", got.from_texture, "last=", got.last_pixel);
                end else begin
                    want = pending_pixels.pop_front();
                    pixels_checked++;
                    if (want.from_texture) tex_pixels++;
                    if (want.last_pixel) run_ends++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("pixel mismatch: expected addr=%h texel=%h %s%h %s%b %s%b",
                                     want.pixel_addr, want.texel_addr,
                                     "colour=", want.color_out,
                                     "tex=", want.from_texture, "last=", want.last_pixel);
                            $display("                got      addr=%h texel=%h %s%h %s%b %s%b",
                                     got.pixel_addr, got.texel_addr,
                                     "colour=", got.color_out,
                                     "tex=", got.from_texture, "last=", got.last_pixel);
                        end
                    end
                end
            end
            if (m_stall > 0) begin
                m_stall--;
            end else if (!m_steady && $urandom_range(0, 3) == 0) begin
                m_stall = pick_gap();
            end
            m_axis_tready <= (m_stall == 0);
        end
    end

    task automatic push_beat(input t_column_beat b);
        beat_q.push_back(b);
        if (b.op != OP_UNUSED) items_queued++;
    endtask

    task automatic push_pixels(input int unsigned n);
        repeat (n) push_beat(random_beat(wcta_pkg::OP_PIXEL));
    endtask

    task automatic wait_idle();
        while (beat_q.size() != 0 || beat_busy || pending_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apply_config(input bit [15:0] sll, input bit [15:0] bpp,
                                input bit [15:0] tw, input bit [15:0] th,
                                input bit [15:0] tll);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= wcta_pkg::CFG_SCREEN_LINE;
        i_cfg_wdata <= sll;
        @(posedge i_clk);
        i_cfg_addr  <= wcta_pkg::CFG_BPP;
        i_cfg_wdata <= bpp;
        @(posedge i_clk);
        i_cfg_addr  <= wcta_pkg::CFG_TEX_WIDTH;
        i_cfg_wdata <= tw;
        @(posedge i_clk);
        i_cfg_addr  <= wcta_pkg::CFG_TEX_HEIGHT;
        i_cfg_wdata <= th;
        @(posedge i_clk);
        i_cfg_addr  <= wcta_pkg::CFG_TEX_LINE;
        i_cfg_wdata <= tll;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_screen_line = sll;
        cfg_bpp         = bpp[3:0];
        cfg_tex_w       = tw[12:0];
        cfg_tex_h       = th[12:0];
        cfg_tex_line    = tll;
        settings++;
    endtask

    task automatic push_corner_cases();
        t_column_beat b;
        // pixel with no open run, then an unused op
        push_beat(random_beat(wcta_pkg::OP_PIXEL));
        push_beat(random_beat(OP_UNUSED));
        // fill run on the last column, then a pixel past its end
        b = random_beat(wcta_pkg::OP_FILL);
        b.column_x = 12'hFFF; b.start_row = 12'd4094; b.end_row = 12'd4095;
        b.fill_color = 32'hFFFF_FFFF;
        push_beat(b);
        push_pixels(2);
        // zero height with full skip and top fraction
        b = random_beat(wcta_pkg::OP_TEX);
        b.vertical = 1'b0; b.hit_x = 28'h000_FFFF; b.wall_height = '0;
        b.skip_rows = 16'hFFFF; b.tex_base = 32'hFFFF_FFFF;
        b.column_x = '0; b.start_row = '0; b.end_row = 12'd3;
        push_beat(b);
        push_pixels(3);
        // tiny height gives a very wide step, replaced early by an empty fill run
        b = random_beat(wcta_pkg::OP_TEX);
        b.vertical = 1'b1; b.hit_y = 28'hFFF_FFFF; b.hit_x = '0;
        b.wall_height = 24'd1; b.skip_rows = '0;
        b.start_row = 12'd10; b.end_row = 12'd12;
        push_beat(b);
        push_pixels(1);
        b = random_beat(wcta_pkg::OP_FILL);
        b.start_row = 12'd5; b.end_row = 12'd5; b.fill_color = '0;
        push_beat(b);
        push_pixels(1);
        // reversed rows, maximum height
        b = random_beat(wcta_pkg::OP_TEX);
        b.wall_height = 24'hFF_FFFF; b.start_row = 12'hFFF; b.end_row = '0;
        push_beat(b);
        push_pixels(1);
        // long fill run cut short by a texture start
        b = random_beat(wcta_pkg::OP_FILL);
        b.start_row = '0; b.end_row = 12'hFFF;
        push_beat(b);
        push_pixels(2);
        b = random_beat(wcta_pkg::OP_TEX);
        b.hit_x = '0; b.hit_y = '0; b.start_row = 12'd100; b.end_row = 12'd102;
        push_beat(b);
        push_pixels(2);
    endtask

    task automatic push_random_run();
        t_column_beat b;
        int unsigned  r, len, npix;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            push_beat(random_beat(OP_UNUSED));
            return;
        end
        if (r < 8) begin
            push_pixels(1);
            return;
        end
        b = random_beat(($urandom_range(0, 99) < 60) ? wcta_pkg::OP_TEX : wcta_pkg::OP_FILL);
        case ($urandom_range(0, 3))
            0: b.wall_height = 24'($urandom);
            1: b.wall_height = 24'($urandom_range(0, 255));
            default: b.wall_height = 24'($urandom_range(256, 1024 * 256));
        endcase
        if ($urandom_range(0, 9) < 8) b.skip_rows = 16'($urandom_range(0, 64));
        r = $urandom_range(0, 99);
        if (r < 88) begin
            len = $urandom_range(1, 12);
            b.start_row = 12'($urandom_range(0, 4095 - len));
            b.end_row   = 12'(b.start_row + len);
            npix = len + ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) == 0) npix = $urandom_range(0, len - 1);
        end else if (r < 98) begin
            npix = $urandom_range(0, 8);
        end else begin
            len = $urandom_range(100, 300);
            b.start_row = 12'($urandom_range(0, 4095 - len));
            b.end_row   = 12'(b.start_row + len);
            npix = len;
        end
        push_beat(b);
        push_pixels(npix);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 7; phase++) begin
            s_steady = (phase == 2);
            m_steady = (phase == 2) || (phase == 5);
            case (phase)
                0: settings++;
                1: apply_config(16'hFFFF, 16'd8, 16'd4096, 16'd4096, 16'hFFFF);
                2: apply_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
                3: apply_config(16'd640, 16'd4, 16'd256, 16'd0, 16'd1024);
                5: apply_config(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
                default: apply_config(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 8)),
                                      16'($urandom_range(1, 4096)),
                                      16'($urandom_range(1, 4096)),
                                      16'($urandom_range(1, 65535)));
            endcase
            if (phase < 2) push_corner_cases();
            while (items_queued < (phase + 1) * 200) push_random_run();
            wait_idle();
        end
        if (pending_pixels.size() != 0) begin
            mismatches += pending_pixels.size();
            $display("%0d predicted pixel beats never arrived", pending_pixels.size());
        end
        $display("%0d column beats over %0d register settings; %0d pixels checked",
                 beats_sent, settings, pixels_checked);
        $display("%0d textured, %0d fill, %0d run ends, %0d mismatches",
                 tex_pixels, pixels_checked - tex_pixels, run_ends, mismatches);
        if (mismatches == 0)
            $display("[wall_column_texel_address_gen] OK");
        else
            $display("[wall_column_texel_address_gen] ERROR");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d beats queued and %0d pixels outstanding",
                 beat_q.size(), pending_pixels.size());
        $display("[wall_column_texel_address_gen] ERROR");
        $finish;
    end

endmodule

### files.f
design/wcta_pkg.sv
design/wcta_div.sv
design/wall_column_texel_address_gen.sv
dv/wall_column_texel_address_gen_tb.sv
